### rtl/efsd_pkg.sv
// shared types and constants for the earliest-free-server dispatch block
package efsd_pkg;

  localparam int FIN_W = 24;
  localparam int SUM_W = 40;
  localparam int CNT_W = 20;
  localparam int ARR_W = 17;
  localparam int SVC_W = 8;
  localparam int SIDX_W = 4;
  localparam int NS_W = 5;
  localparam int CLOSE_W = 16;
  localparam int CFG_W = 16;
  localparam int SVC_SEC_W = 14;

  localparam logic [SVC_SEC_W-1:0] SECS_PER_MIN = 14'd60;
  localparam logic [FIN_W-1:0] FIN_MAX = {FIN_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [NS_W-1:0] NUM_SERVERS_RESET = 5'd1;
  localparam logic [CLOSE_W-1:0] CLOSE_TIME_RESET = 16'd32400;

  typedef enum logic {
    CFG_NUM_SERVERS = 1'b0,
    CFG_CLOSE_TIME  = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CALC,
    ST_WRITE,
    ST_FINISH
  } state_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic sample;
    logic used;
  } scan_ctrl_t;

  typedef struct packed {
    logic found_free;
    logic have_best;
  } scan_status_t;

endpackage

### rtl/efsd_job_if.sv
// job channel: arrival time and service length
interface efsd_job_if;
  import efsd_pkg::*;

  logic valid;
  logic ready;
  logic signed [ARR_W-1:0] arrival_seconds;
  logic [SVC_W-1:0] service_minutes;

  modport source (output valid, arrival_seconds, service_minutes, input ready);
  modport sink (input valid, arrival_seconds, service_minutes, output ready);
endinterface

### rtl/efsd_result_if.sv
// result channel: dispatch decision and running totals
interface efsd_result_if;
  import efsd_pkg::*;

  logic valid;
  logic ready;
  logic accepted;
  logic [SIDX_W-1:0] server_index;
  logic [FIN_W-1:0] wait_seconds;
  logic [SUM_W-1:0] total_wait;
  logic [CNT_W-1:0] served_count;

  modport source (output valid, accepted, server_index, wait_seconds, total_wait,
                  served_count, input ready);
  modport sink (input valid, accepted, server_index, wait_seconds, total_wait,
                served_count, output ready);
endinterface

### rtl/efsd_store.sv
// per-server finish time memory and in-use flags
module efsd_store
  import efsd_pkg::*;
#(
  parameter int MAX_SERVERS = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [FIN_W-1:0] rd_data,
  output logic             rd_used,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [FIN_W-1:0] wr_data
);

  logic [FIN_W-1:0] mem [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] used;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
    rd_used <= used[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (wr_en) begin
      used[wr_addr] <= 1'b1;
    end
  end

endmodule

### rtl/efsd_argmin.sv
// shared compare unit: first free server or earliest finish, one server a cycle
module efsd_argmin
  import efsd_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  scan_ctrl_t       ctrl,
  input  logic [IDX_W-1:0] idx,
  input  logic [FIN_W-1:0] value,
  output scan_status_t     status,
  output logic [IDX_W-1:0] sel,
  output logic [FIN_W-1:0] best
);

  logic take;

  // strict less-than keeps the lowest index on ties
  assign take = !status.found_free && ctrl.used && (!status.have_best || value < best);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      status <= '0;
    end else if (ctrl.sample && !status.found_free) begin
      if (!ctrl.used) begin
        status.found_free <= 1'b1;
      end else begin
        status.have_best <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sample && !status.found_free) begin
      if (!ctrl.used) begin
        sel <= idx;
      end else if (take) begin
        sel <= idx;
        best <= value;
      end
    end
  end

endmodule

### rtl/earliest_free_server_dispatch.sv
// earliest-free-server dispatch: top level with sequencer and wait arithmetic
//
// Each job on the job channel is dispatched to the lowest unused server, or
// else to the server that finishes first (lowest index on ties), and one
// result with the job's wait and the running totals goes out per job. A job
// arriving after close_time goes straight to the finish state and changes no
// state. For an accepted job, one compare unit walks the k active servers, where k
// is the active server count (num_servers clamped to 1..MAX_SERVERS), one per
// cycle through the single read port of the finish time memory; then the calc and
// write states work out the wait and the new finish time. The job channel is not
// ready while a job is in progress; a finished result waits in the output
// register while the next job is taken. Configuration must be written through
// cfg_write, cfg_index and cfg_data only while no job is in flight; the block
// itself does not enforce this.
module earliest_free_server_dispatch
  import efsd_pkg::*;
#(
  parameter int MAX_SERVERS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  efsd_job_if.sink            job,
  efsd_result_if.source       result
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int NW = 8;
  localparam int DIFF_W = FIN_W + 2;

  state_t state, state_next;

  logic [NS_W-1:0] num_servers;
  logic [CLOSE_W-1:0] close_time;
  logic [SUM_W-1:0] wait_sum;
  logic [CNT_W-1:0] job_count;

  logic signed [ARR_W-1:0] arrival;
  logic [SVC_W-1:0] minutes;
  logic rejected;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] last;
  logic sample_d;
  logic [IDX_W-1:0] idx_d;
  logic [FIN_W-1:0] wait_w;
  logic [FIN_W-1:0] base;

  logic [FIN_W-1:0] rd_data;
  logic rd_used;
  logic wr_en;
  logic [FIN_W-1:0] wr_data;
  scan_ctrl_t ctrl;
  scan_status_t status;
  logic [IDX_W-1:0] sel;
  logic [FIN_W-1:0] best;

  logic [NW-1:0] ns_w;
  logic late;
  logic job_xfer;
  logic load;
  logic [FIN_W-1:0] start;
  logic signed [DIFF_W-1:0] diff;
  logic [SVC_SEC_W-1:0] service;
  logic [FIN_W:0] fin_sum;
  logic [SUM_W:0] sum_next;

  // active server count clamped to 1..MAX_SERVERS, as a last index
  assign ns_w = NW'(num_servers);
  always_comb begin
    priority if (ns_w == '0) begin
      last = '0;
    end else if (ns_w > NW'(MAX_SERVERS)) begin
      last = IDX_W'(MAX_SERVERS - 1);
    end else begin
      last = IDX_W'(ns_w - NW'(1));
    end
  end

  assign late = job.arrival_seconds > $signed({1'b0, close_time});
  assign job.ready = (state == ST_IDLE);
  assign job_xfer = job.valid && job.ready;

  // result register frees up on its own transfer
  assign load = (state == ST_FINISH) && (!result.valid || result.ready);

  always_comb begin
    state_next = state;
    ctrl = '0;
    wr_en = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (job_xfer) begin
          ctrl.clear = 1'b1;
          state_next = late ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_CALC;
      end
      ST_CALC: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        wr_en = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    ctrl.sample = sample_d;
    ctrl.used = rd_used;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_servers <= NUM_SERVERS_RESET;
      close_time <= CLOSE_TIME_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_NUM_SERVERS: num_servers <= cfg_data[NS_W-1:0];
        CFG_CLOSE_TIME:  close_time <= cfg_data[CLOSE_W-1:0];
        default: ;
      endcase
    end
  end

  // read data is registered, so the sample flag and index are delayed to match
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_d <= 1'b0;
    end else begin
      sample_d <= (state == ST_SCAN);
    end
    idx_d <= cnt;
  end

  always_ff @(posedge clk) begin
    if (job_xfer) begin
      arrival <= job.arrival_seconds;
      minutes <= job.service_minutes;
      rejected <= late;
      cnt <= '0;
    end else if (state == ST_SCAN && cnt != last) begin
      cnt <= cnt + IDX_W'(1);
    end
  end

  // wait = start - arrival, saturated; base is where the service starts
  assign start = status.found_free ? '0 : best;
  assign diff = $signed({2'b00, start}) - DIFF_W'(arrival);

  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      if (diff > 0) begin
        wait_w <= (diff > $signed({2'b00, FIN_MAX})) ? FIN_MAX : diff[FIN_W-1:0];
        base <= start;
      end else begin
        wait_w <= '0;
        base <= FIN_W'(arrival[ARR_W-2:0]);
      end
    end
  end

  assign service = SVC_SEC_W'(minutes) * SECS_PER_MIN;
  assign fin_sum = {1'b0, base} + (FIN_W + 1)'(service);
  assign wr_data = fin_sum[FIN_W] ? FIN_MAX : fin_sum[FIN_W-1:0];

  assign sum_next = {1'b0, wait_sum} + (SUM_W + 1)'(wait_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_sum <= '0;
      job_count <= '0;
    end else if (load && !rejected) begin
      wait_sum <= sum_next[SUM_W] ? SUM_MAX : sum_next[SUM_W-1:0];
      if (job_count != CNT_MAX) begin
        job_count <= job_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (rejected) begin
        result.accepted <= 1'b0;
        result.server_index <= '0;
        result.wait_seconds <= '0;
        result.total_wait <= wait_sum;
        result.served_count <= job_count;
      end else begin
        result.accepted <= 1'b1;
        result.server_index <= SIDX_W'(sel);
        result.wait_seconds <= wait_w;
        result.total_wait <= sum_next[SUM_W] ? SUM_MAX : sum_next[SUM_W-1:0];
        result.served_count <= (job_count != CNT_MAX) ? job_count + CNT_W'(1) : job_count;
      end
    end
  end

  efsd_store #(
    .MAX_SERVERS(MAX_SERVERS),
    .IDX_W(IDX_W)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_addr(cnt),
    .rd_data(rd_data),
    .rd_used(rd_used),
    .wr_en  (wr_en),
    .wr_addr(sel),
    .wr_data(wr_data)
  );

  efsd_argmin #(
    .IDX_W(IDX_W)
  ) u_argmin (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .idx   (idx_d),
    .value (rd_data),
    .status(status),
    .sel   (sel),
    .best  (best)
  );

`ifndef SYNTH
  a_reject_keeps_sum: assert property (@(posedge clk) disable iff (rst)
    (load && rejected) |=> $stable(wait_sum) && $stable(job_count))
    else $error("rejected job changed the running totals");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> job_count >= $past(job_count))
    else $error("served count went down");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> sel <= last)
    else $error("finish time written outside the active servers");

  a_reject_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.accepted) |-> (result.wait_seconds == '0 &&
      result.server_index == '0))
    else $error("rejected result carries a wait or a server");

  a_scan_sample_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) |-> (status.found_free || status.have_best))
    else $error("scan ended with no server chosen");
`endif

endmodule

### tb/efsd_dispatch_checker.sv
`timescale 1ns / 100ps
// passive checker: predicts each dispatch result and compares it with the block output
module efsd_dispatch_checker
  import efsd_pkg::*;
#(
  parameter int MAX_SERVERS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  efsd_job_if              job,
  efsd_result_if           result,
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    logic              accepted;
    logic [SIDX_W-1:0] server_index;
    logic [FIN_W-1:0]  wait_seconds;
    logic [SUM_W-1:0]  total_wait;
    logic [CNT_W-1:0]  served_count;
  } dispatch_t;

  logic [NS_W-1:0]    active_servers;
  logic [CLOSE_W-1:0] close_time;
  logic [FIN_W-1:0]   finish_at [MAX_SERVERS];
  logic               server_taken [MAX_SERVERS];
  logic [SUM_W-1:0]   wait_total;
  logic [CNT_W-1:0]   jobs_served;
  dispatch_t          dispatch_q [$];

  function automatic logic [FIN_W-1:0] clamp_fin(longint v);
    if (v < 0) return '0;
    if (v > longint'(FIN_MAX)) return FIN_MAX;
    return v[FIN_W-1:0];
  endfunction

  function automatic dispatch_t dispatch_job(longint arr, longint svc_secs);
    dispatch_t        r;
    int               k;
    int               sel;
    longint           start;
    longint           gap;
    longint           sum;
    logic [FIN_W-1:0] w;
    r = '0;
    k = active_servers;
    if (k < 1) k = 1;
    if (k > MAX_SERVERS) k = MAX_SERVERS;
    // late arrival: report running totals, touch nothing
    if (arr > longint'(close_time)) begin
      r.total_wait = wait_total;
      r.served_count = jobs_served;
      return r;
    end
    sel = -1;
    for (int i = 0; i < k; i++) begin
      if (sel < 0 && !server_taken[i]) sel = i;
    end
    if (sel < 0) begin
      sel = 0;
      for (int i = 1; i < k; i++) begin
        if (finish_at[i] < finish_at[sel]) sel = i;
      end
      start = finish_at[sel];
    end else begin
      start = 0;
      server_taken[sel] = 1'b1;
    end
    gap = start - arr;
    if (gap > 0) begin
      w = clamp_fin(gap);
      finish_at[sel] = clamp_fin(start + svc_secs);
    end else begin
      w = '0;
      finish_at[sel] = clamp_fin(arr + svc_secs);
    end
    sum = longint'(wait_total) + longint'(w);
    wait_total = (sum > longint'(SUM_MAX)) ? SUM_MAX : sum[SUM_W-1:0];
    if (jobs_served != CNT_MAX) jobs_served++;
    r.accepted = 1'b1;
    r.server_index = sel[SIDX_W-1:0];
    r.wait_seconds = w;
    r.total_wait = wait_total;
    r.served_count = jobs_served;
    return r;
  endfunction

  task automatic flag_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    dispatch_t want;
    dispatch_t got;
    dispatch_t pred;
    if (rst) begin
      active_servers = NUM_SERVERS_RESET;
      close_time = CLOSE_TIME_RESET;
      for (int i = 0; i < MAX_SERVERS; i++) begin
        finish_at[i] = '0;
        server_taken[i] = 1'b0;
      end
      wait_total = '0;
      jobs_served = '0;
      dispatch_q.delete();
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_NUM_SERVERS) active_servers = cfg_data[NS_W-1:0];
        else close_time = cfg_data[CLOSE_W-1:0];
      end
      if (result.valid && result.ready) begin
        got = {result.accepted, result.server_index, result.wait_seconds,
               result.total_wait, result.served_count};
        if (dispatch_q.size() == 0) begin
          flag_failure("result transfer with no job outstanding");
        end else begin
          want = dispatch_q.pop_front();
          if (got !== want)
            flag_failure($sformatf({"mismatch: expected acc=%0d srv=%0d wait=%0d total=%0d ",
                                    "count=%0d, got acc=%0d srv=%0d wait=%0d total=%0d count=%0d"},
                                   want.accepted, want.server_index, want.wait_seconds,
                                   want.total_wait, want.served_count, got.accepted,
                                   got.server_index, got.wait_seconds, got.total_wait,
                                   got.served_count));
        end
      end
      if (job.valid && job.ready) begin
        pred = dispatch_job($signed(job.arrival_seconds),
                            longint'(job.service_minutes) * longint'(SECS_PER_MIN));
        dispatch_q = {dispatch_q, pred};
      end
      outstanding = dispatch_q.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// top of the dispatch testbench: clock, reset, job and register stimulus, verdict
module testbench;
  import efsd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 30;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             gaps_on = 1'b0;
  logic             hold_req = 1'b0;
  int               mismatches;
  int               outstanding;
  int               cycle_count = 0;

  efsd_job_if    job ();
  efsd_result_if result ();

  earliest_free_server_dispatch #(.MAX_SERVERS(16)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job       (job),
    .result    (result)
  );

  efsd_dispatch_checker #(.MAX_SERVERS(16)) chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .job         (job),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    result.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        result.ready = 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        result.ready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        result.ready = 1'b1;
      end else begin
        result.ready = 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_job(input logic signed [ARR_W-1:0] arr, input logic [SVC_W-1:0] svc);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      job.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    job.valid = 1'b1;
    job.arrival_seconds = arr;
    job.service_minutes = svc;
    do @(posedge clk); while (!job.ready);
    @(negedge clk);
  endtask

  task automatic drain;
    job.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [NS_W-1:0] servers, input logic [CLOSE_W-1:0] close);
    drain();
    cfg_write = 1'b1;
    cfg_index = CFG_NUM_SERVERS;
    cfg_data = CFG_W'(servers);
    @(negedge clk);
    cfg_index = CFG_CLOSE_TIME;
    cfg_data = close;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // mostly ascending arrivals with random spacing; some noise and backward steps
  task automatic random_jobs(input int count, input int step_max, input int svc_lo,
                             input int svc_hi, input logic allow_gaps);
    int                       cur;
    logic signed [ARR_W-1:0]  arr;
    logic [SVC_W-1:0]         svc;
    cur = -int'($urandom_range(0, 28800));
    for (int n = 0; n < count; n++) begin
      gaps_on = allow_gaps && ((n % 80) < 56);
      if ($urandom_range(0, 9) == 0) begin
        arr = ARR_W'($urandom);
      end else begin
        if ($urandom_range(0, 19) == 0) cur -= int'($urandom_range(0, 3000));
        else cur += int'($urandom_range(0, step_max));
        if (cur > 65535) cur = -int'($urandom_range(0, 28800));
        arr = ARR_W'(cur);
      end
      if ($urandom_range(0, 7) == 0) svc = $urandom_range(0, 1) ? SVC_W'(svc_hi) : SVC_W'(svc_lo);
      else svc = SVC_W'($urandom_range(svc_lo, svc_hi));
      send_job(arr, svc);
    end
    gaps_on = 1'b0;
  endtask

  initial begin
    job.valid = 1'b0;
    job.arrival_seconds = '0;
    job.service_minutes = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_NUM_SERVERS;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // one server, default close: long early wait, close boundary, extreme arrivals
    send_job(17'sd0, 8'd0);
    send_job(-17'sd28800, 8'd255);
    send_job(17'sd32400, 8'd1);
    send_job(17'sd32401, 8'd10);
    send_job(17'sh0FFFF, 8'd255);
    send_job(17'sh10000, 8'd0);

    // fill all sixteen servers, then earliest-free choice and out-of-order arrivals
    configure(5'd16, 16'd57599);
    for (int i = 0; i < 16; i++) send_job(ARR_W'(i * 10), SVC_W'(i));
    send_job(17'sd57599, 8'd255);
    send_job(-17'sd100, 8'd3);

    // zero server count acts as one; close at opening
    configure(5'd0, 16'd0);
    send_job(17'sd0, 8'd5);
    send_job(17'sd1, 8'd5);

    // server count above the maximum; widest close time
    configure(5'd31, 16'hFFFF);
    send_job(17'sh0FFFF, 8'd255);

    configure(5'd16, 16'd57599);
    hold_req = 1'b1;
    random_jobs(40, 1500, 0, 255, 1'b1);

    configure(5'd3, 16'd32400);
    random_jobs(25, 4000, 0, 255, 1'b1);

    configure(5'd0, 16'd20000);
    random_jobs(20, 3000, 0, 60, 1'b1);

    configure(5'd8, 16'hFFFF);
    random_jobs(25, 800, 0, 255, 1'b1);

    // stack long jobs on one server until its finish time and the waits saturate
    configure(5'd1, 16'd57599);
    gaps_on = 1'b1;
    for (int n = 0; n < 1110; n++) begin
      send_job(ARR_W'(-int'($urandom_range(0, 28800))), 8'd255);
    end
    gaps_on = 1'b0;

    // saturated server 0 among the other servers, no stalls on either side
    configure(5'd16, 16'd57599);
    random_jobs(40, 600, 0, 255, 1'b0);

    drain();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
